>>> hdl/assert_macros.svh
// assertion helpers for the tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define LPST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lpst assertion failed");

// clocked assertion, also checked during reset
`define LPST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lpst assertion failed");

`endif

>>> hdl/lpst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpst_pkg;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] leg0_x;
    logic signed [15:0] leg0_y;
    logic signed [15:0] leg1_x;
    logic signed [15:0] leg1_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               leg0_visible;
    logic               leg1_visible;
    logic [9:0]         new_diameter;
  } in_beat_t;

  typedef struct packed {
    logic signed [39:0] leftness_out;
    logic signed [15:0] facing_out;
    logic [12:0]        separation_out;
    logic [9:0]         diameter_out;
  } out_beat_t;

  // item modes
  localparam logic [1:0] MODE_PERSON  = 2'd0;
  localparam logic [1:0] MODE_DIAM    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // register indexes
  localparam logic [1:0] REG_LGAIN = 2'd0;
  localparam logic [1:0] REG_SGAIN = 2'd1;
  localparam logic [1:0] REG_MSEP  = 2'd2;
  localparam logic [1:0] REG_IDIAM = 2'd3;

  localparam logic [15:0] LGAIN_RST = 16'd6554;
  localparam logic [15:0] SGAIN_RST = 16'd6554;
  localparam logic [11:0] MSEP_RST  = 12'd350;
  localparam logic [9:0]  IDIAM_RST = 10'd150;

  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [15:0] HALF_TURN    = 16'h8000;
  localparam logic signed [42:0] LEFT_MAX = 43'sd549755813887;
  localparam logic signed [42:0] LEFT_MIN = -43'sd549755813888;

  // multiplier operand widths
  localparam int MulAW = 26;
  localparam int MulBW = 18;
  localparam int MulPW = MulAW + MulBW;

  // cordic angle constant and state widths
  localparam int CorW = 28;
  localparam int CorZW = 27;
  localparam logic signed [CorZW-1:0] COR_HALF = 27'sd8388608;

  typedef enum logic [4:0] {
    ST_IDLE, ST_S0, ST_S1, ST_S2, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6,
    ST_FW, ST_F0, ST_F1, ST_PW, ST_P0, ST_P1, ST_D0, ST_D1, ST_DONE
  } state_e;

  // arctangent table in 2^-24 turn
  function automatic logic signed [CorZW-1:0] atan_lut(input logic [3:0] i);
    logic signed [CorZW-1:0] v;
    case (i)
      4'd0:  v = 27'sd2097152;
      4'd1:  v = 27'sd1238021;
      4'd2:  v = 27'sd654136;
      4'd3:  v = 27'sd332050;
      4'd4:  v = 27'sd166669;
      4'd5:  v = 27'sd83416;
      4'd6:  v = 27'sd41718;
      4'd7:  v = 27'sd20860;
      4'd8:  v = 27'sd10430;
      4'd9:  v = 27'sd5215;
      4'd10: v = 27'sd2608;
      4'd11: v = 27'sd1304;
      4'd12: v = 27'sd652;
      4'd13: v = 27'sd326;
      4'd14: v = 27'sd163;
      default: v = 27'sd81;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hdl/lpst_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module lpst_mul (
  input  wire logic                               clk_i,
  input  wire logic signed [lpst_pkg::MulAW-1:0]  a_i,
  input  wire logic signed [lpst_pkg::MulBW-1:0]  b_i,
  output logic signed [lpst_pkg::MulPW-1:0]       prod_o
);
  import lpst_pkg::*;

  // shared signed multiplier with registered product
  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule
`default_nettype wire

>>> hdl/lpst_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module lpst_cordic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [16:0] x_i,
  input  wire logic signed [16:0] y_i,
  output logic                    busy_o,
  output logic [15:0]             angle_o
);
  import lpst_pkg::*;

  logic signed [CorW-1:0]  x_q, y_q, x_d, y_d, xs, ys;
  logic signed [CorZW-1:0] z_q, z_d, zr;
  logic [3:0]              it_q;
  logic                    busy_q, zero_q;

  // one rotation step per cycle
  always_comb begin
    xs = x_q >>> it_q;
    ys = y_q >>> it_q;
    if (y_q > 0) begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + atan_lut(it_q);
    end else begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - atan_lut(it_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      it_q   <= '0;
    end else if (busy_q) begin
      it_q <= it_q + 4'd1;
      if (it_q == 4'd15) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath, left half plane folded over first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == 17'sd0) && (y_i == 17'sd0);
      if (x_i < 0) begin
        x_q <= -({{(CorW-25){x_i[16]}}, x_i, 8'd0});
        y_q <= -({{(CorW-25){y_i[16]}}, y_i, 8'd0});
        z_q <= COR_HALF;
      end else begin
        x_q <= {{(CorW-25){x_i[16]}}, x_i, 8'd0};
        y_q <= {{(CorW-25){y_i[16]}}, y_i, 8'd0};
        z_q <= '0;
      end
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  // round to 2^-16 turn
  assign zr      = z_q + 27'sd128;
  assign angle_o = zero_q ? 16'd0 : zr[23:8];
  assign busy_o  = busy_q;

endmodule
`default_nettype wire

>>> hdl/lpst_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module lpst_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [33:0] sq_i,
  output logic             busy_o,
  output logic [16:0]      root_o
);
  import lpst_pkg::*;

  logic [34:0] n_q, r_q, bitv, trial;
  logic [4:0]  k_q;
  logic        busy_q;

  assign bitv  = 35'd1 << {k_q, 1'b0};
  assign trial = r_q + bitv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      k_q    <= 5'd16;
    end else if (busy_q) begin
      k_q <= k_q - 5'd1;
      if (k_q == 5'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // one result bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= {1'b0, sq_i};
      r_q <= '0;
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_q <= n_q - trial;
        r_q <= (r_q >> 1) + bitv;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = r_q[16:0];

endmodule
`default_nettype wire

>>> hdl/leg_pair_statistics_tracker.sv
// a person update passes the leftness, facing and, with both legs visible, separation steps
// a diameter update takes one multiply; restart and the unused mode go straight to done
// throughput: one item at a time; the next item is accepted once the result has entered
//   the output register and the tracker is back in idle
// the cordic runs 16 rotation steps and the square root 17 steps beside the multiplier
// reset: averages and registers take their reset values, output empty
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module leg_pair_statistics_tracker (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire lpst_pkg::in_beat_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output lpst_pkg::out_beat_t       out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import lpst_pkg::*;

  state_e state_q, state_d;
  logic [15:0] lgain_q, sgain_q;
  logic [11:0] msep_q;
  logic [9:0]  idiam_q;

  logic signed [16:0] dx_q, dy_q, dx_in, dy_in;
  logic signed [15:0] vx_q, vy_q;
  logic               both_q;
  logic signed [57:0] acc_q;
  logic signed [40:0] diff_q;
  logic signed [39:0] left_q;
  logic [15:0]        face_q;
  logic [12:0]        sep_q;
  logic [9:0]         diam_q;
  out_beat_t          out_q;
  logic               out_valid_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;
  logic signed [17:0]      gain_s;

  logic        cor_busy, sq_busy, sq_start, accept, cfg_wr;
  logic [15:0] cor_angle, cur;
  logic [16:0] root;
  logic [33:0] sq_sum;
  logic signed [42:0] left_new;
  logic signed [27:0] sep_new;
  logic [12:0] sep_hi, sep_lo;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign dx_in = 17'(in_data_i.leg1_x) - 17'(in_data_i.leg0_x);
  assign dy_in = 17'(in_data_i.leg1_y) - 17'(in_data_i.leg0_y);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lgain_q <= LGAIN_RST;
      sgain_q <= SGAIN_RST;
      msep_q  <= MSEP_RST;
      idiam_q <= IDIAM_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LGAIN: lgain_q <= pwdata[15:0];
        REG_SGAIN: sgain_q <= pwdata[15:0];
        REG_MSEP:  msep_q  <= pwdata[11:0];
        REG_IDIAM: idiam_q <= pwdata[9:0];
        default:   lgain_q <= lgain_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LGAIN: prdata = {16'd0, lgain_q};
      REG_SGAIN: prdata = {16'd0, sgain_q};
      REG_MSEP:  prdata = {20'd0, msep_q};
      REG_IDIAM: prdata = {22'd0, idiam_q};
      default:   prdata = '0;
    endcase
  end

  // shared units
  lpst_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  lpst_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && (in_data_i.mode == MODE_PERSON)),
    .x_i     (dx_in),
    .y_i     (dy_in),
    .busy_o  (cor_busy),
    .angle_o (cor_angle)
  );

  assign sq_sum   = acc_q[33:0] + prod[33:0];
  assign sq_start = (state_q == ST_S2) && both_q;

  lpst_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .sq_i    (sq_sum),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and multiplier operands
  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    gain_s  = {2'b0, sgain_q};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.mode)
            MODE_PERSON: state_d = ST_S0;
            MODE_DIAM:   state_d = ST_D0;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_S0: begin
        mul_a   = MulAW'(dx_q);
        mul_b   = MulBW'(dx_q);
        state_d = ST_S1;
      end
      ST_S1: begin
        mul_a   = MulAW'(dy_q);
        mul_b   = MulBW'(dy_q);
        state_d = ST_S2;
      end
      ST_S2: begin
        mul_a   = MulAW'(dx_q);
        mul_b   = -(MulBW'(vy_q));
        state_d = ST_L1;
      end
      ST_L1: begin
        mul_a   = MulAW'(dy_q);
        mul_b   = MulBW'(vx_q);
        state_d = ST_L2;
      end
      ST_L2: state_d = ST_L3;
      ST_L3: begin
        mul_a   = {2'b0, diff_q[23:0]};
        mul_b   = {2'b0, lgain_q};
        state_d = ST_L4;
      end
      ST_L4: begin
        mul_a   = MulAW'($signed(diff_q[40:24]));
        mul_b   = {2'b0, lgain_q};
        state_d = ST_L5;
      end
      ST_L5: state_d = ST_L6;
      ST_L6: state_d = ST_FW;
      ST_FW: begin
        if (!cor_busy) begin
          state_d = ST_F0;
        end
      end
      ST_F0: begin
        mul_a   = diff_q[MulAW-1:0];
        mul_b   = gain_s;
        state_d = ST_F1;
      end
      ST_F1: state_d = both_q ? ST_PW : ST_DONE;
      ST_PW: begin
        if (!sq_busy) begin
          state_d = ST_P0;
        end
      end
      ST_P0: begin
        mul_a   = diff_q[MulAW-1:0];
        mul_b   = gain_s;
        state_d = ST_P1;
      end
      ST_P1: state_d = ST_DONE;
      ST_D0: begin
        mul_a   = diff_q[MulAW-1:0];
        mul_b   = gain_s;
        state_d = ST_D1;
      end
      ST_D1: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // leftness with saturation, facing target, separation clamp
  assign left_new = 43'(left_q) + 43'($signed(acc_q[57:16]));
  always_comb begin
    cur = cor_angle + QUARTER_TURN;
    if (left_q < 0) begin
      cur = cur - HALF_TURN;
    end
  end
  assign sep_new = 28'({15'd0, sep_q}) + prod[43:16];
  assign sep_hi  = {msep_q, 1'b0};
  assign sep_lo  = {2'd0, msep_q[11:1]};

  // item latch and scratch registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q   <= dx_in;
      dy_q   <= dy_in;
      vx_q   <= in_data_i.vel_x;
      vy_q   <= in_data_i.vel_y;
      both_q <= in_data_i.leg0_visible && in_data_i.leg1_visible;
      diff_q <= 41'($signed({1'b0, in_data_i.new_diameter})) -
                41'($signed({1'b0, diam_q}));
    end
    case (state_q)
      ST_S1, ST_L1: acc_q <= 58'(prod);
      ST_L2: diff_q <= 41'(acc_q) + 41'(prod) - 41'(left_q);
      ST_L4: acc_q <= 58'(prod);
      ST_L5: acc_q <= acc_q + {prod[33:0], 24'd0};
      ST_FW: diff_q <= 41'($signed(cur - face_q));
      ST_PW: diff_q <= 41'($signed({1'b0, root})) - 41'($signed({1'b0, sep_q}));
      default: acc_q <= acc_q;
    endcase
  end

  // running averages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      face_q <= '0;
      sep_q  <= 13'(MSEP_RST);
      diam_q <= IDIAM_RST;
    end else if (accept && (in_data_i.mode == MODE_RESTART)) begin
      left_q <= '0;
      face_q <= '0;
      sep_q  <= {1'b0, msep_q};
      diam_q <= idiam_q;
    end else begin
      case (state_q)
        ST_L6: begin
          if (left_new > LEFT_MAX) begin
            left_q <= LEFT_MAX[39:0];
          end else if (left_new < LEFT_MIN) begin
            left_q <= LEFT_MIN[39:0];
          end else begin
            left_q <= left_new[39:0];
          end
        end
        ST_F1: face_q <= face_q + prod[31:16];
        ST_P1: begin
          if (sep_new > 28'($signed({1'b0, sep_hi}))) begin
            sep_q <= sep_hi;
          end else if (sep_new < 28'($signed({1'b0, sep_lo}))) begin
            sep_q <= sep_lo;
          end else begin
            sep_q <= sep_new[12:0];
          end
        end
        ST_D1: diam_q <= diam_q + prod[25:16];
        default: diam_q <= diam_q;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_q.leftness_out   <= left_q;
      out_q.facing_out     <= face_q;
      out_q.separation_out <= sep_q;
      out_q.diameter_out   <= diam_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LPST_ASSERT(a_cordic_idle, (state_q == ST_IDLE) |-> !cor_busy)
  `LPST_ASSERT(a_sqrt_idle, (state_q == ST_IDLE) |-> !sq_busy)
  `LPST_ASSERT(a_out_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
  `LPST_ASSERT_ALWAYS(a_pready, pready)

endmodule
`default_nettype wire
